>>> rtl/core/fixed_block_pool_allocator_core_macros.svh
// Assertion macros used by the allocator checker.
// Depends on nothing; include by bare file name.
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define FBPA_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fbpa assertion failed");

// Next-cycle implication.
`define FBPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fbpa assertion failed");

`endif

>>> rtl/core/fbpa_pkg.sv
// Shared types and constants of the fixed block pool allocator.
// Used by every core module but fbpa_ram; depends on nothing.
package fbpa_pkg;

    localparam int BLOCK_COUNT_DEF = 256;
    localparam int BLOCK_BYTES_DEF = 64;
    localparam int ADDR_BITS_DEF   = 32;

    localparam int WORD_BITS  = 32;
    localparam int STAT_BITS  = 9;
    localparam int CFG_IDX_BITS = 1;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    localparam logic [CFG_IDX_BITS-1:0] REG_POOL_ENABLE = 1'b0;
    localparam logic [CFG_IDX_BITS-1:0] REG_POOL_BASE   = 1'b1;

    typedef struct packed {
        logic                 cmd;
        logic [WORD_BITS-1:0] req_size;
        logic [WORD_BITS-1:0] free_addr;
    } req_t;

    typedef struct packed {
        logic [WORD_BITS-1:0] block_addr;
        logic                 from_pool;
        logic                 to_heap;
        logic                 bad_free;
        logic [STAT_BITS-1:0] free_count;
        logic [STAT_BITS-1:0] low_water;
        logic [WORD_BITS-1:0] fallbacks;
    } rsp_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic commit;
        logic cfg_write;
    } ctrl_cmd_t;

endpackage

>>> rtl/core/fbpa_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
module fbpa_ram #(
    parameter int WIDTH = 9,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/fbpa_ctrl.sv
// Controller of the allocator: sequences capture and commit of each word and gates configuration writes.
// Depends on fbpa_pkg.
module fbpa_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               req_valid,
    output logic               req_stall,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    output fbpa_pkg::ctrl_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_EXEC = 2'b10
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   rsp_valid_reg;
    logic   rsp_valid_next;

    always_comb
    begin
        state_next     = state_reg;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        cmd            = '0;
        // hold configuration off while a word is offered or in flight
        cfg_ready      = (state_reg == ST_IDLE) && !req_valid;
        cmd.cfg_write  = cfg_valid && cfg_ready;
        case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                // hold until the result register is free
                if (!rsp_valid_reg || !rsp_stall)
                begin
                    cmd.commit     = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

endmodule

>>> rtl/core/fbpa_dp.sv
// Datapath of the allocator: free list, link RAM, statistics, result register.
// Depends on fbpa_pkg and fbpa_ram.
module fbpa_dp #(
    parameter int BLOCK_COUNT = fbpa_pkg::BLOCK_COUNT_DEF,
    parameter int BLOCK_BYTES = fbpa_pkg::BLOCK_BYTES_DEF,
    parameter int ADDR_BITS   = fbpa_pkg::ADDR_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  fbpa_pkg::ctrl_cmd_t                 cmd,
    input  fbpa_pkg::req_t                      req_word,
    input  logic [fbpa_pkg::CFG_IDX_BITS-1:0]   cfg_index,
    input  logic [fbpa_pkg::WORD_BITS-1:0]      cfg_data,
    output fbpa_pkg::rsp_t                      rsp_word
);

    localparam int IDX_BITS  = $clog2(BLOCK_COUNT);
    localparam int CNT_BITS  = $clog2(BLOCK_COUNT + 1);
    localparam int LOG_B     = $clog2(BLOCK_BYTES);
    localparam int HOFF_BITS = CNT_BITS + LOG_B + 1;
    localparam longint unsigned ARENA_BYTES = longint'(BLOCK_COUNT) * longint'(BLOCK_BYTES);
    localparam int OFF_BITS  = $clog2(ARENA_BYTES);
    localparam int SHIFT     = OFF_BITS + LOG_B;
    localparam longint unsigned RECIP =
        ((longint'(1) << SHIFT) + longint'(BLOCK_BYTES) - 1) / longint'(BLOCK_BYTES);
    localparam int RECIP_BITS = OFF_BITS + 2;
    localparam int PROD_BITS  = OFF_BITS + RECIP_BITS;

    // configuration
    logic                          enable_reg;
    logic [fbpa_pkg::WORD_BITS-1:0] base_reg;

    // free list and statistics
    logic [CNT_BITS-1:0]            head_reg;
    logic [CNT_BITS-1:0]            head_next;
    logic [CNT_BITS-1:0]            free_reg;
    logic [CNT_BITS-1:0]            free_next;
    logic [CNT_BITS-1:0]            min_reg;
    logic [CNT_BITS-1:0]            min_next;
    logic [fbpa_pkg::WORD_BITS-1:0] fallback_reg;
    logic [fbpa_pkg::WORD_BITS-1:0] fallback_next;
    logic [BLOCK_COUNT-1:0]         link_valid_reg;

    // captured request
    logic                 cmd_reg;
    logic                 size_ok_reg;
    logic                 null_reg;
    logic [ADDR_BITS-1:0] off_reg;
    logic [HOFF_BITS-1:0] head_off_reg;

    fbpa_pkg::rsp_t rsp_reg;
    fbpa_pkg::rsp_t rsp_next;

    logic [CNT_BITS-1:0]  link_rdata;
    logic [CNT_BITS-1:0]  link_val;
    logic [IDX_BITS-1:0]  head_idx;
    logic [IDX_BITS-1:0]  blk;
    logic [PROD_BITS-1:0] prod;
    logic [63:0]          off_wide;
    logic [ADDR_BITS-1:0] granted;
    logic                 in_arena;
    logic                 head_ok;
    logic                 grant;
    logic                 fallback;
    logic                 free_req;
    logic                 push;
    logic                 bad;
    logic                 to_heap;
    logic                 init;

    assign head_idx = head_reg[IDX_BITS-1:0];
    assign init = cmd.cfg_write && (cfg_index == fbpa_pkg::REG_POOL_ENABLE)
                  && cfg_data[0] && !enable_reg;

    fbpa_ram #(
        .WIDTH (CNT_BITS),
        .DEPTH (BLOCK_COUNT)
    ) u_link_ram (
        .clk   (clk),
        .we    (cmd.commit && push),
        .waddr (blk),
        .wdata (head_reg),
        .re    (cmd.capture),
        .raddr (head_idx),
        .rdata (link_rdata)
    );

    // An entry never written since init reads as its successor index.
    assign link_val = link_valid_reg[head_idx] ? link_rdata : head_reg + CNT_BITS'(1);

    // Block index from the arena offset: multiply by reciprocal, drop the fraction.
    assign prod     = PROD_BITS'(OFF_BITS'(off_reg)) * PROD_BITS'(RECIP);
    assign blk      = IDX_BITS'(prod >> SHIFT);
    assign off_wide = 64'(off_reg);
    assign in_arena = off_wide < ARENA_BYTES;
    assign granted  = ADDR_BITS'(base_reg) + ADDR_BITS'(head_off_reg);
    assign head_ok  = head_reg < CNT_BITS'(BLOCK_COUNT);

    always_comb
    begin
        grant    = (cmd_reg == fbpa_pkg::CMD_ALLOC) && enable_reg && size_ok_reg
                   && (free_reg != '0) && head_ok;
        fallback = (cmd_reg == fbpa_pkg::CMD_ALLOC) && enable_reg && !grant;
        free_req = (cmd_reg == fbpa_pkg::CMD_FREE) && !null_reg;
        push     = free_req && enable_reg && in_arena
                   && (free_reg < CNT_BITS'(BLOCK_COUNT));
        bad      = free_req && enable_reg && in_arena
                   && (free_reg >= CNT_BITS'(BLOCK_COUNT));
        to_heap  = ((cmd_reg == fbpa_pkg::CMD_ALLOC) && !grant)
                   || (free_req && (!enable_reg || !in_arena));

        head_next     = head_reg;
        free_next     = free_reg;
        min_next      = min_reg;
        fallback_next = fallback_reg;
        if (grant)
        begin
            head_next = link_val;
            free_next = free_reg - CNT_BITS'(1);
            if (free_next < min_reg)
            begin
                min_next = free_next;
            end
        end
        else if (push)
        begin
            head_next = CNT_BITS'(blk);
            free_next = free_reg + CNT_BITS'(1);
        end
        if (fallback)
        begin
            fallback_next = fallback_reg + fbpa_pkg::WORD_BITS'(1);
        end

        rsp_next.block_addr = grant ? fbpa_pkg::WORD_BITS'(granted) : '0;
        rsp_next.from_pool  = grant || push;
        rsp_next.to_heap    = to_heap;
        rsp_next.bad_free   = bad;
        rsp_next.free_count = enable_reg ? fbpa_pkg::STAT_BITS'(free_next) : '0;
        rsp_next.low_water  = enable_reg ? fbpa_pkg::STAT_BITS'(min_next) : '0;
        rsp_next.fallbacks  = enable_reg ? fallback_next : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg     <= 1'b0;
            base_reg       <= '0;
            head_reg       <= '0;
            free_reg       <= CNT_BITS'(BLOCK_COUNT);
            min_reg        <= CNT_BITS'(BLOCK_COUNT);
            fallback_reg   <= '0;
            link_valid_reg <= '0;
        end
        else
        begin
            if (cmd.cfg_write)
            begin
                case (cfg_index)
                    fbpa_pkg::REG_POOL_ENABLE: enable_reg <= cfg_data[0];
                    fbpa_pkg::REG_POOL_BASE:   base_reg   <= cfg_data;
                    default:                   ;
                endcase
            end
            if (init)
            begin
                head_reg       <= '0;
                free_reg       <= CNT_BITS'(BLOCK_COUNT);
                min_reg        <= CNT_BITS'(BLOCK_COUNT);
                fallback_reg   <= '0;
                link_valid_reg <= '0;
            end
            else if (cmd.commit)
            begin
                head_reg     <= head_next;
                free_reg     <= free_next;
                min_reg      <= min_next;
                fallback_reg <= fallback_next;
                if (push)
                begin
                    link_valid_reg[blk] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            cmd_reg      <= req_word.cmd;
            size_ok_reg  <= (req_word.req_size != '0)
                            && (req_word.req_size <= fbpa_pkg::WORD_BITS'(BLOCK_BYTES));
            null_reg     <= (req_word.free_addr == '0);
            off_reg      <= ADDR_BITS'(req_word.free_addr) - ADDR_BITS'(base_reg);
            head_off_reg <= HOFF_BITS'(head_reg) * HOFF_BITS'(BLOCK_BYTES);
        end
        if (cmd.commit)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_word = rsp_reg;

endmodule

>>> rtl/core/fixed_block_pool_allocator_core.sv
// Fixed block pool allocator: a LIFO free list of equal blocks in one arena.
// Each request word is first captured, which reads the head block's link from
// the synchronous link RAM, then committed, which updates the list and
// statistics and loads the result register; a stalled result holds back the
// next word only at its commit. A new word is taken while the previous
// result still waits. Every block has a valid bit, so reset and enabling the
// pool need no clearing pass. Depends on fbpa_pkg, fbpa_ctrl, fbpa_dp, fbpa_ram.
module fixed_block_pool_allocator_core #(
    parameter int BLOCK_COUNT = fbpa_pkg::BLOCK_COUNT_DEF,
    parameter int BLOCK_BYTES = fbpa_pkg::BLOCK_BYTES_DEF,
    parameter int ADDR_BITS   = fbpa_pkg::ADDR_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  fbpa_pkg::req_t                    req_word,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output fbpa_pkg::rsp_t                    rsp_word,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [fbpa_pkg::CFG_IDX_BITS-1:0] cfg_index,
    input  logic [fbpa_pkg::WORD_BITS-1:0]    cfg_data
);

    fbpa_pkg::ctrl_cmd_t cmd;

    fbpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cmd       (cmd)
    );

    fbpa_dp #(
        .BLOCK_COUNT (BLOCK_COUNT),
        .BLOCK_BYTES (BLOCK_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req_word  (req_word),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_word  (rsp_word)
    );

endmodule

>>> rtl/core/fbpa_checker.sv
// Port-level checks of the allocator core, bound to the top level.
// Depends on fbpa_pkg and fixed_block_pool_allocator_core_macros.svh.
`include "fixed_block_pool_allocator_core_macros.svh"

module fbpa_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input fbpa_pkg::rsp_t rsp_word
);

    `FBPA_ASSERT_IMPLY(a_pool_xor_heap, clk, rst_n, rsp_valid, !(rsp_word.from_pool && rsp_word.to_heap))
    `FBPA_ASSERT_IMPLY(a_addr_only_granted, clk, rst_n, rsp_valid && (rsp_word.block_addr != '0), rsp_word.from_pool)
    `FBPA_ASSERT_IMPLY(a_low_water_bound, clk, rst_n, rsp_valid, rsp_word.low_water <= rsp_word.free_count)
    `FBPA_ASSERT_NEXT(a_rsp_held, clk, rst_n, rsp_valid && rsp_stall, rsp_valid)

endmodule

bind fixed_block_pool_allocator_core fbpa_checker u_fbpa_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_word  (rsp_word)
);
